FILE: src/ilu_pkg.sv
// Shared constants and types for the integer LU decomposition core.
`timescale 1ns / 1ps
`default_nettype none
package ilu_pkg;
  localparam int MaxDim = 4;
  localparam int Cells = MaxDim * MaxDim;
  localparam int IdxW = $clog2(MaxDim);

  localparam logic [0:0] RegNumRows = 1'b0;
  localparam logic [0:0] RegNumCols = 1'b1;

  // Operation broadcast along the row of cells.
  typedef struct packed {
    logic        load;      // write data into the addressed cell
    logic        update;    // cell(k) -= mult * pivot_row(k)
    logic [IdxW-1:0] sel;   // addressed cell
  } ilu_cmd_t;

  function automatic logic [2:0] clamp_dim(input logic [2:0] v);
    if (v == 3'd0) return 3'd1;
    if (v > 3'(MaxDim)) return 3'(MaxDim);
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: src/integer_lu_decomposition_core.sv
// Integer LU decomposition core: top level with sequencer and output port.
//
// Usage: write num_rows (index 0) and num_cols (index 1) through the cfg
// port while idle; any write restarts loading. Feed r*c elements in
// row-major order on element/element_valid (one per cycle while
// element_stall is low). After the last element the core eliminates with
// no pivoting. Each multiplier passes through an issue state (S_DIV), a
// wait on the 32-step serial division (S_WAIT) and a row-update state
// (S_UPD); a zero pivot skips the division. There are M = sum of (r-1-i)
// over pivot columns i < min(r-1, c) multipliers, six for a 4x4 matrix.
// The core then sends r*c entries of L and r*c entries of U, one per
// cycle unless result_stall is high. last marks the final U entry.
// element_stall stays high from the last element until the last result
// transfer. While result_stall is high the current result holds. Reset
// returns num_rows and num_cols to 4 and clears loading. Matrix words sit
// in a grid of cells; a row's words from the pivot column on update
// together in S_UPD. The multiplier store L is set to a unit diagonal
// (within r and c) at each elimination start.
`timescale 1ns / 1ps
`default_nettype none
module integer_lu_decomposition_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        element_valid,
  output logic             element_stall,
  input  wire logic signed [31:0] element,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic signed [31:0] value,
  output logic             which_matrix,
  output logic [1:0]       row_index,
  output logic [1:0]       col_index,
  output logic             zero_pivot,
  output logic             last
);
  import ilu_pkg::*;
  typedef enum logic [2:0] {S_LOAD, S_DIV, S_WAIT, S_UPD, S_OUT} st_t;
  st_t st;
  logic [2:0] num_rows, num_cols, r, c;
  logic [4:0] load_count;
  logic [1:0] ld_row, ld_col, pi, pj, oi, oj;
  logic       omat, perr;
  logic [31:0] u [MaxDim][MaxDim];
  logic [31:0] l [MaxDim][MaxDim];
  logic [31:0] mult;
  logic        dstart, ddone;
  logic [31:0] dq;
  ilu_cmd_t    cmd [MaxDim];
  logic [31:0] piv;

  assign r = clamp_dim(num_rows);
  assign c = clamp_dim(num_cols);
  assign piv = u[pi][pi];

  ilu_div u_div (.clk, .rst, .start(dstart), .dividend(u[pj][pi]), .divisor(piv),
    .done(ddone), .quotient(dq));

  for (genvar ri = 0; ri < MaxDim; ri++) begin : g_row
    always_comb begin
      cmd[ri] = '0;
      if (st == S_LOAD && element_valid && 2'(ri) == ld_row) begin
        cmd[ri].load = 1'b1; cmd[ri].sel = ld_col;
      end
    end
    for (genvar ci = 0; ci < MaxDim; ci++) begin : g_col
      ilu_cmd_t cc;
      always_comb begin
        cc = cmd[ri];
        if (st == S_UPD && 2'(ri) == pj && 3'(ci) >= {1'b0, pi} && 3'(ci) < c) begin
          cc.update = 1'b1; cc.sel = 2'(ci);
        end
      end
      ilu_cell u_cell (.clk, .cmd(cc), .my_idx(2'(ci)), .shift(1'b0),
        .shift_in(32'd0), .load_data(element), .mult(mult),
        .piv_word(u[pi][ci]), .word(u[ri][ci]));
    end
  end

  assign element_stall = (st != S_LOAD);
  assign result_valid = (st == S_OUT);
  assign value = omat ? u[oi][oj] : l[oi][oj];
  assign which_matrix = omat;
  assign row_index = oi;
  assign col_index = oj;
  assign zero_pivot = perr;
  assign last = omat && (3'(oi) + 3'd1 == r) && (3'(oj) + 3'd1 == c);

  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    if (rst) begin
      st <= S_LOAD; num_rows <= 3'd4; num_cols <= 3'd4;
      load_count <= '0; ld_row <= '0; ld_col <= '0; perr <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == RegNumRows) num_rows <= cfg_data;
      else num_cols <= cfg_data;
      load_count <= '0; ld_row <= '0; ld_col <= '0;
    end else begin
      unique case (st)
        S_LOAD: if (element_valid) begin
          if (load_count + 5'd1 == 5'(r * c)) begin
            load_count <= '0; ld_row <= '0; ld_col <= '0;
            perr <= 1'b0;
            for (int a = 0; a < MaxDim; a++)
              for (int b = 0; b < MaxDim; b++)
                l[a][b] <= (a == b && a < int'(r) && a < int'(c)) ? 32'd1 : 32'd0;
            pi <= '0; pj <= 2'd1;
            if (r > 3'd1) begin st <= S_DIV; end
            else begin st <= S_OUT; oi <= '0; oj <= '0; omat <= 1'b0; end
          end else begin
            if (3'(ld_col) + 3'd1 == c) begin
              ld_col <= '0; ld_row <= ld_row + 2'd1;
            end else ld_col <= ld_col + 2'd1;
            load_count <= load_count + 5'd1;
          end
        end
        S_DIV: begin
          if (piv == 32'd0) begin
            perr <= 1'b1; mult <= '0; l[pj][pi] <= '0; st <= S_UPD;
          end else begin dstart <= 1'b1; st <= S_WAIT; end
        end
        S_WAIT: if (ddone) begin mult <= dq; l[pj][pi] <= dq; st <= S_UPD; end
        S_UPD: begin
          if (3'(pj) + 3'd1 < r) begin pj <= pj + 2'd1; st <= S_DIV; end
          else if (3'(pi) + 3'd2 < r && 3'(pi) + 3'd1 < c) begin
            pi <= pi + 2'd1; pj <= pi + 2'd2; st <= S_DIV;
          end else begin st <= S_OUT; oi <= '0; oj <= '0; omat <= 1'b0; end
        end
        S_OUT: if (!result_stall) begin
          if (3'(oj) + 3'd1 < c) oj <= oj + 2'd1;
          else begin
            oj <= '0;
            if (3'(oi) + 3'd1 < r) oi <= oi + 2'd1;
            else begin
              oi <= '0;
              if (omat) st <= S_LOAD; else omat <= 1'b1;
            end
          end
        end
        default: st <= S_LOAD;
      endcase
    end
  end

  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> element_stall) else $error("result while loading");
  a_last_u: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> which_matrix) else $error("last on L entry");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(row_index)
      && $stable(col_index) && $stable(which_matrix)))
    else $error("result moved under stall");
endmodule
`default_nettype wire

FILE: src/ilu_div.sv
// Radix-2 signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module ilu_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  import ilu_pkg::*;
  logic [31:0] rem, quo, mag_d;
  logic        neg, busy;
  logic [5:0]  cnt;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, mag_d};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= 6'd32;
      rem   <= '0;
      quo   <= dividend[31] ? 32'(-dividend) : dividend;
      mag_d <= divisor[31] ? 32'(-divisor) : divisor;
      neg   <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
  assign quotient = neg ? 32'(-quo) : quo;
endmodule
`default_nettype wire

FILE: src/ilu_cell.sv
// One word of a matrix row: load, multiply-subtract update, shift to neighbor.
`timescale 1ns / 1ps
`default_nettype none
module ilu_cell (
  input  wire logic        clk,
  input  wire ilu_pkg::ilu_cmd_t cmd,
  input  wire logic [ilu_pkg::IdxW-1:0] my_idx,
  input  wire logic        shift,
  input  wire logic [31:0] shift_in,
  input  wire logic [31:0] load_data,
  input  wire logic [31:0] mult,
  input  wire logic [31:0] piv_word,
  output logic [31:0]      word
);
  import ilu_pkg::*;
  logic [31:0] prod;
  assign prod = 32'(mult * piv_word);
  always_ff @(posedge clk) begin
    if (shift) word <= shift_in;
    else if (cmd.sel == my_idx) begin
      if (cmd.load) word <= load_data;
      else if (cmd.update) word <= word - prod;
    end
  end
endmodule
`default_nettype wire
